// ===== design/jsu_pkg.sv =====
// Shared types, character codes and UTF-8 helpers for the JSON string unescaper.
// No dependencies; compiled first.
package jsu_pkg;

   typedef enum logic [3:0] {
      M_WAIT     = 4'd0,
      M_BODY     = 4'd1,
      M_ESC      = 4'd2,
      M_HEX      = 4'd3,
      M_HELD     = 4'd4,
      M_HELD_ESC = 4'd5,
      M_HELD_HEX = 4'd6
   } mode_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_QUOTE = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Most results one item can raise (held surrogate plus a following BMP code)
   localparam int unsigned BURST_DEPTH = 6;

   localparam logic [7:0]  CHAR_QUOTE  = 8'h22;
   localparam logic [7:0]  CHAR_BSLASH = 8'h5C;
   localparam logic [7:0]  CHAR_U      = 8'h75;

   localparam logic [15:0] SURR_HIGH_LO = 16'hD800;
   localparam logic [15:0] SURR_HIGH_HI = 16'hDBFF;
   localparam logic [15:0] SURR_LOW_LO  = 16'hDC00;
   localparam logic [15:0] SURR_LOW_HI  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] value;
   } entry_type;

   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] bytes;   // bytes[0] goes out first
   } utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } hex_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] value;
   } esc_type;

   function automatic utf8_type utf8_enc(input logic [20:0] cp);
      utf8_type r;
      r = '0;
      if (cp <= 21'h7F) begin
         r.len      = 3'd1;
         r.bytes[0] = cp[7:0];
      end else if (cp <= 21'h7FF) begin
         r.len      = 3'd2;
         r.bytes[0] = {3'b110, cp[10:6]};
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp <= 21'hFFFF) begin
         r.len      = 3'd3;
         r.bytes[0] = {4'b1110, cp[15:12]};
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = {5'b11110, cp[20:18]};
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type r;
      r = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.ok    = 1'b1;
         r.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r.ok    = 1'b1;
         r.value = c[3:0] + 4'd9;
      end
      return r;
   endfunction

   function automatic esc_type simple_esc(input logic [7:0] c);
      esc_type r;
      r.ok = 1'b1;
      case (c)
         8'h22:   r.value = 8'h22;  // "
         8'h5C:   r.value = 8'h5C;  // backslash
         8'h2F:   r.value = 8'h2F;  // /
         8'h62:   r.value = 8'h08;  // b
         8'h66:   r.value = 8'h0C;  // f
         8'h6E:   r.value = 8'h0A;  // n
         8'h72:   r.value = 8'h0D;  // r
         8'h74:   r.value = 8'h09;  // t
         default: begin
            r.ok    = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== design/jsu_if.sv =====
// Valid/ready channel interfaces for the unescaper: raw bytes in, results out.
// No dependencies.
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_final;

   modport source (output valid, output in_byte, output in_final, input ready);
   modport sink   (input valid, input in_byte, input in_final, output ready);
endinterface

interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] value;
   logic       run_end;

   modport source (output valid, output kind, output value, output run_end, input ready);
   modport sink   (input valid, input kind, input value, input run_end, output ready);
endinterface

// ===== design/json_string_unescape_utf8_top.sv =====
// JSON string unescaper with UTF-8 output of \u escapes and surrogate pairing.
// An item's first result is on rsp in the cycle after it is accepted. Throughput:
// one item per cycle while each raises at most one result and rsp is ready; an
// item raising n results (up to 6) holds the result buffer until all leave, and
// the next is taken in the cycle its last result leaves. Synchronous active-high
// reset clears parser state and the result buffer. Depends on jsu_pkg, jsu_if.
module json_string_unescape_utf8_top (
   input logic       clock,
   input logic       reset,
   jsu_req_if.sink   req_chan,
   jsu_rsp_if.source rsp_chan
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] held_ff, held_in;

   entry_type [BURST_DEPTH-1:0] burst_ff, burst_in, new_burst;
   logic [2:0] burst_cnt_ff, burst_cnt_in, new_len;

   logic accept, pop;

   logic [7:0]      c;
   hex_type         hex_r;
   esc_type         esc_r;
   logic [15:0]     hex_acc;
   logic [20:0]     pair_cp;
   utf8_type        held_enc, cp_enc;
   logic            err, emit_held, do_body, do_finish, b_is_cp;
   logic [15:0]     fin_cp;
   logic [20:0]     b_cp;
   kind_type        b_kind;
   logic [2:0]      b_len;
   logic [3:0][7:0] b_bytes;

   assign c        = req_chan.in_byte;
   assign hex_r    = hex_digit(c);
   assign esc_r    = simple_esc(c);
   assign hex_acc  = {accum_ff[11:0], hex_r.value};
   assign pair_cp  = SUPP_BASE + {1'b0, held_ff[9:0], hex_acc[9:0]};
   assign held_enc = utf8_enc({5'd0, held_ff});
   assign cp_enc   = utf8_enc(b_cp);

   // handshakes: the buffer reloads when empty or when its last result leaves
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (burst_cnt_ff == 3'd0) || (burst_cnt_ff == 3'd1 && rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // parser step
   always_comb begin
      mode_in   = mode_ff;
      accum_in  = accum_ff;
      count_in  = count_ff;
      held_in   = held_ff;
      err       = 1'b0;
      emit_held = 1'b0;
      do_body   = 1'b0;
      do_finish = 1'b0;
      fin_cp    = hex_acc;
      b_is_cp   = 1'b0;
      b_cp      = '0;
      b_kind    = KIND_DATA;
      b_len     = 3'd0;
      b_bytes   = '0;

      unique case (mode_ff)
         M_BODY: begin
            do_body = 1'b1;
         end
         M_ESC: begin
            if (c == CHAR_U) begin
               mode_in  = M_HEX;
               accum_in = '0;
               count_in = '0;
            end else if (!esc_r.ok) begin
               err = 1'b1;
            end else begin
               b_len      = 3'd1;
               b_bytes[0] = esc_r.value;
               mode_in    = M_BODY;
            end
         end
         M_HEX, M_HELD_HEX: begin
            if (!hex_r.ok) begin
               err = 1'b1;
            end else if (count_ff != 2'd3) begin
               accum_in = hex_acc;
               count_in = count_ff + 2'd1;
            end else begin
               count_in = '0;
               if (mode_ff == M_HEX) begin
                  do_finish = 1'b1;
               end else if (hex_acc >= SURR_LOW_LO && hex_acc <= SURR_LOW_HI) begin
                  b_is_cp  = 1'b1;
                  b_cp     = pair_cp;
                  held_in  = '0;
                  accum_in = '0;
                  mode_in  = M_BODY;
               end else begin
                  emit_held = 1'b1;
                  held_in   = '0;
                  do_finish = 1'b1;
               end
            end
         end
         M_HELD: begin
            if (c == CHAR_BSLASH) begin
               mode_in = M_HELD_ESC;
            end else begin
               emit_held = 1'b1;
               held_in   = '0;
               do_body   = 1'b1;
            end
         end
         M_HELD_ESC: begin
            if (c == CHAR_U) begin
               mode_in  = M_HELD_HEX;
               accum_in = '0;
               count_in = '0;
            end else if (!esc_r.ok) begin
               err = 1'b1;
            end else begin
               emit_held  = 1'b1;
               held_in    = '0;
               b_len      = 3'd1;
               b_bytes[0] = esc_r.value;
               mode_in    = M_BODY;
            end
         end
         default: begin
            if (c == CHAR_QUOTE) begin
               mode_in  = M_BODY;
               accum_in = '0;
               count_in = '0;
               held_in  = '0;
            end else begin
               err = 1'b1;
            end
         end
      endcase

      if (do_body) begin
         if (c == CHAR_QUOTE) begin
            b_kind   = KIND_QUOTE;
            b_len    = 3'd1;
            mode_in  = M_WAIT;
            accum_in = '0;
            count_in = '0;
            held_in  = '0;
         end else if (c == CHAR_BSLASH) begin
            mode_in = M_ESC;
         end else begin
            b_len      = 3'd1;
            b_bytes[0] = c;
            mode_in    = M_BODY;
         end
      end

      if (do_finish) begin
         accum_in = '0;
         if (fin_cp >= SURR_HIGH_LO && fin_cp <= SURR_HIGH_HI) begin
            held_in = fin_cp;
            mode_in = M_HELD;
         end else begin
            b_is_cp = 1'b1;
            b_cp    = {5'd0, fin_cp};
            mode_in = M_BODY;
         end
      end

      if (b_is_cp) begin
         b_len   = cp_enc.len;
         b_bytes = cp_enc.bytes;
      end

      if (req_chan.in_final && mode_in != M_WAIT) begin
         err = 1'b1;
      end

      if (err) begin
         mode_in  = M_WAIT;
         accum_in = '0;
         count_in = '0;
         held_in  = '0;
      end
   end

   // pack the results of this item into burst order
   always_comb begin
      for (int i = 0; i < BURST_DEPTH; i++) begin
         new_burst[i] = '{kind: KIND_DATA, value: 8'h00};
      end
      if (err) begin
         new_burst[0] = '{kind: KIND_ERROR, value: 8'h00};
         new_len      = 3'd1;
      end else if (emit_held) begin
         // after a held surrogate at most a BMP code, a quote or one byte follows
         for (int i = 0; i < 3; i++) begin
            new_burst[i] = '{kind: KIND_DATA, value: held_enc.bytes[i]};
         end
         for (int i = 0; i < 3; i++) begin
            new_burst[3+i] = '{kind: b_kind, value: b_bytes[i]};
         end
         new_len = 3'd3 + b_len;
      end else begin
         for (int i = 0; i < 4; i++) begin
            new_burst[i] = '{kind: b_kind, value: b_bytes[i]};
         end
         new_len = b_len;
      end
   end

   // result buffer: reload on accept, else shift one out per taken result
   always_comb begin
      burst_in     = burst_ff;
      burst_cnt_in = burst_cnt_ff;
      if (accept) begin
         burst_in     = new_burst;
         burst_cnt_in = new_len;
      end else if (pop) begin
         for (int i = 0; i < BURST_DEPTH - 1; i++) begin
            burst_in[i] = burst_ff[i+1];
         end
         burst_cnt_in = burst_cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_WAIT;
         accum_ff     <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         burst_cnt_ff <= '0;
      end else begin
         burst_cnt_ff <= burst_cnt_in;
         if (accept) begin
            mode_ff  <= mode_in;
            accum_ff <= accum_in;
            count_ff <= count_in;
            held_ff  <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      burst_ff <= burst_in;
   end

   assign rsp_chan.valid   = (burst_cnt_ff != 3'd0);
   assign rsp_chan.kind    = burst_ff[0].kind;
   assign rsp_chan.value   = burst_ff[0].value;
   assign rsp_chan.run_end = (burst_cnt_ff == 3'd1);

`ifndef SYNTH
   // an error is always the only result of its item
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.kind == KIND_ERROR) |-> rsp_chan.run_end)
      else $error("error result not last of its item");

   // a final byte always leaves the parser waiting for a new literal
   a_final_closes: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.in_final) |=> (mode_ff == M_WAIT))
      else $error("parser open after final byte");

   // a held surrogate exists only in the held modes
   a_held_mode: assert property (@(posedge clock) disable iff (reset)
      (held_ff != 16'h0000) |->
         (mode_ff == M_HELD || mode_ff == M_HELD_ESC || mode_ff == M_HELD_HEX))
      else $error("held surrogate outside held modes");
`endif

endmodule
